### rtl/core/hcb_pkg.sv
// Package: shared types and constants for the Huffman code builder/encoder.
package hcb_pkg;

    localparam int ActionWidth = 2;
    localparam int SymbolWidth = 8;
    localparam int StatusWidth = 3;
    localparam int CodeOutWidth = 32;
    localparam int LenOutWidth = 6;
    localparam int FreqOutWidth = 16;
    localparam int DistinctOutWidth = 8;

    typedef enum logic [ActionWidth-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_COUNT  = 2'd1,
        ACT_BUILD  = 2'd2,
        ACT_ENCODE = 2'd3
    } action_t;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK        = 3'd0,
        ST_SATURATED = 3'd1,
        ST_ABSENT    = 3'd2,
        ST_PHASE     = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef struct packed {
        status_t                     status;
        logic [DistinctOutWidth-1:0] distinct_count;
        logic [CodeOutWidth-1:0]     code_bits;
        logic [LenOutWidth-1:0]      code_length;
        logic [FreqOutWidth-1:0]     frequency;
    } result_t;

endpackage

### rtl/core/hcb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/huffman_code_builder_encoder_core.sv
// Top level: two-pass Huffman code builder and encoder over byte symbols.
//
// Channel   Dir  tdata fields (low bit up)                          Handshake
// s_axis    in   action[1:0], symbol[9:2], zero fill to 16 bits     tvalid/tready
// m_axis    out  status[2:0], distinct_count[10:3], code_bits[42:11],
//                code_length[48:43], frequency[64:49], zero fill to 72   tvalid/tready
//
// Sequence: count and encode each pass through accept, memory read, then
//   write back or lookup; errors answer straight from the accept state. A build
//   runs a leaf pass (read, then check) over the alphabet entries, then each
//   node taken scans the heap one entry per cycle, then the code walk steps
//   through read, wait, left and right per internal node and the code table
//   fill through read, wait and write per leaf.
// Reset: counts live in a RAM; a clearing pass over all ALPHABET_SIZE entries
//   runs after reset and for every clear word, during which no word is accepted.
// Stalls: the result is held in an output register; a new word is accepted
//   only once the previous result has been taken.
module huffman_code_builder_encoder_core
    import hcb_pkg::*;
#(
    parameter int ALPHABET_SIZE   = 256,
    parameter int COUNT_WIDTH     = 16,
    parameter int MAX_CODE_LENGTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // action[1:0], symbol[9:2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata    // status, distinct_count, code_bits,
                                        // code_length, frequency
);
    localparam int SW = $clog2(ALPHABET_SIZE);
    localparam int NDEPTH = 2 * ALPHABET_SIZE;
    localparam int NW = $clog2(NDEPTH);
    localparam int HW = SW + 1;
    localparam int WW = COUNT_WIDTH + SW;          // node weight width
    localparam int LW = $clog2(MAX_CODE_LENGTH + 1);
    // node: left, right, weight, minsym
    localparam int NODEW = 2 * NW + WW + SW;
    localparam int CODEW = MAX_CODE_LENGTH + LW;
    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_CNT_RD, S_CNT_WR, S_ENC_RD, S_ENC_WAIT, S_OUT,
        S_LEAF_RD, S_LEAF_CHK, S_SCAN_RD, S_SCAN, S_TAKE_WR, S_MERGE_RD,
        S_MERGE_WAIT, S_MERGE_WR, S_WALK_RD, S_WALK_WAIT, S_WALK_L, S_WALK_R,
        S_FILL_RD, S_FILL_WAIT, S_FILL_WR
    } state_t;

    state_t state_reg;

    // Count RAM
    logic             cnt_we;
    logic [SW-1:0]    cnt_waddr, cnt_raddr;
    logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
    // Tree node RAM
    logic             nd_we;
    logic [NW-1:0]    nd_waddr, nd_raddr;
    logic [NODEW-1:0] nd_wdata, nd_rdata;
    // Heap RAM
    logic             hp_we;
    logic [SW-1:0]    hp_waddr, hp_raddr;
    logic [NW-1:0]    hp_wdata, hp_rdata;
    // Walk RAM (code + len per node)
    logic             wk_we;
    logic [NW-1:0]    wk_waddr, wk_raddr;
    logic [CODEW-1:0] wk_wdata, wk_rdata;
    // Code table
    logic             ct_we;
    logic [SW-1:0]    ct_waddr, ct_raddr;
    logic [CODEW-1:0] ct_wdata, ct_rdata;

    hcb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(ALPHABET_SIZE)) u_cnt (
        .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
        .raddr(cnt_raddr), .rdata(cnt_rdata));
    hcb_ram #(.WIDTH(NODEW), .DEPTH(NDEPTH)) u_node (
        .clk, .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
        .raddr(nd_raddr), .rdata(nd_rdata));
    hcb_ram #(.WIDTH(NW), .DEPTH(ALPHABET_SIZE)) u_heap (
        .clk, .we(hp_we), .waddr(hp_waddr), .wdata(hp_wdata),
        .raddr(hp_raddr), .rdata(hp_rdata));
    hcb_ram #(.WIDTH(CODEW), .DEPTH(NDEPTH)) u_walk (
        .clk, .we(wk_we), .waddr(wk_waddr), .wdata(wk_wdata),
        .raddr(wk_raddr), .rdata(wk_rdata));
    hcb_ram #(.WIDTH(CODEW), .DEPTH(ALPHABET_SIZE)) u_code (
        .clk, .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
        .raddr(ct_raddr), .rdata(ct_rdata));

    // Control and working registers
    logic              built_reg;
    logic [HW-1:0]     distinct_reg;
    logic [SW-1:0]     sym_reg;
    logic [SW:0]       idx_reg;          // general sweep index (holds ALPHABET_SIZE)
    logic [NW-1:0]     leaves_reg, next_reg, k_reg;
    logic [HW-1:0]     hsize_reg;
    logic [SW-1:0]     scan_reg;         // heap entry being examined
    logic [SW-1:0]     best_pos_reg;
    logic [NW-1:0]     best_node_reg;
    logic [WW-1:0]     best_w_reg;
    logic [SW-1:0]     best_m_reg;
    logic              second_reg;       // taking second node of a merge
    logic [NW-1:0]     a_node_reg;
    logic [WW-1:0]     a_w_reg;
    logic [SW-1:0]     a_m_reg;
    logic [NW-1:0]     ch_l_reg, ch_r_reg;
    logic [CODEW-1:0]  pcode_reg;
    result_t           res_reg;
    logic              out_valid_reg;
    logic [NW-1:0]     nd_raddr_d_reg;   // node index that produced nd_rdata during the scan
    logic [HW-1:0]     last_pos;         // heap tail position

    assign last_pos = hsize_reg - 1'b1;

    // Unpack
    logic [NW-1:0] nd_left, nd_right;
    logic [WW-1:0] nd_w;
    logic [SW-1:0] nd_m;
    assign {nd_left, nd_right, nd_w, nd_m} = nd_rdata;

    action_t in_action;
    logic [SymbolWidth-1:0] in_sym;
    assign in_action = action_t'(s_axis_tdata[1:0]);
    assign in_sym = s_axis_tdata[9:2];
    logic sym_ok;
    assign sym_ok = (in_sym != '0) && ({1'b0, in_sym} < 9'(ALPHABET_SIZE));

    assign s_axis_tready = (state_reg == S_IDLE) && !out_valid_reg;
    logic in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Status known at accept time; anything but ok answers at once
    status_t idle_status;
    always_comb
    begin
        idle_status = ST_OK;
        case (in_action)
            ACT_COUNT:
            begin
                if (!sym_ok)
                    idle_status = ST_ABSENT;
                else if (built_reg)
                    idle_status = ST_PHASE;
            end
            ACT_BUILD:
            begin
                if (distinct_reg == '0)
                    idle_status = ST_EMPTY;
            end
            ACT_ENCODE:
            begin
                if (!built_reg)
                    idle_status = ST_PHASE;
                else if (!sym_ok)
                    idle_status = ST_ABSENT;
            end
            default: ;
        endcase
    end

    // Code extension helper
    logic [MAX_CODE_LENGTH-1:0] pc_bits;
    logic [LW-1:0]              pc_len;
    assign {pc_bits, pc_len} = pcode_reg;
    logic pc_full;
    assign pc_full = (pc_len >= LW'(MAX_CODE_LENGTH));

    // Combinational memory addressing
    always_comb
    begin
        cnt_we = 1'b0; cnt_waddr = sym_reg; cnt_wdata = '0; cnt_raddr = in_sym[SW-1:0];
        nd_we = 1'b0; nd_waddr = next_reg; nd_wdata = '0; nd_raddr = hp_rdata;
        hp_we = 1'b0; hp_waddr = best_pos_reg; hp_wdata = '0;
        hp_raddr = scan_reg;
        wk_we = 1'b0; wk_waddr = ch_l_reg; wk_wdata = '0; wk_raddr = k_reg;
        ct_we = 1'b0; ct_waddr = nd_m; ct_wdata = wk_rdata; ct_raddr = in_sym[SW-1:0];
        case (state_reg)
            S_CLEAR:
            begin
                cnt_we = 1'b1;
                cnt_waddr = idx_reg[SW-1:0];
            end
            S_CNT_WR:
            begin
                cnt_we = (cnt_rdata != CountMax);
                cnt_wdata = cnt_rdata + 1'b1;
            end
            S_LEAF_RD: cnt_raddr = idx_reg[SW-1:0];
            S_LEAF_CHK:
            begin
                cnt_raddr = idx_reg[SW-1:0];
                if (cnt_rdata != '0)
                begin
                    nd_we = 1'b1;
                    nd_waddr = leaves_reg;
                    nd_wdata = {{NW{1'b1}}, {NW{1'b1}}, WW'(cnt_rdata),
                                SW'(idx_reg)};
                    hp_we = 1'b1;
                    hp_waddr = hsize_reg[SW-1:0];
                    hp_wdata = leaves_reg;
                end
            end
            S_SCAN_RD: hp_raddr = '0;
            S_SCAN:
            begin
                // once every entry is issued, fetch the tail for the take
                hp_raddr = ((HW)'(scan_reg) < hsize_reg) ? scan_reg : last_pos[SW-1:0];
            end
            S_TAKE_WR:
            begin
                hp_we = 1'b1;
                hp_waddr = best_pos_reg;
                hp_raddr = SW'(hsize_reg - 1'b1);
                hp_wdata = hp_rdata;
            end
            S_MERGE_WR:
            begin
                nd_we = 1'b1;
                nd_waddr = next_reg;
                nd_wdata = {a_node_reg, best_node_reg, a_w_reg + best_w_reg,
                            (a_m_reg < best_m_reg) ? a_m_reg : best_m_reg};
                hp_we = 1'b1;
                hp_waddr = hsize_reg[SW-1:0];
                hp_wdata = next_reg;
            end
            S_WALK_RD:
            begin
                nd_raddr = k_reg;
                wk_raddr = k_reg;
                if (k_reg == NW'(next_reg - 1'b1))
                begin
                    wk_we = 1'b1;
                    wk_waddr = k_reg;
                    wk_wdata = '0;
                end
            end
            S_WALK_L:
            begin
                wk_we = 1'b1;
                wk_waddr = ch_l_reg;
                wk_wdata = pc_full ? pcode_reg
                         : {pc_bits << 1, LW'(pc_len + 1'b1)};
            end
            S_WALK_R:
            begin
                wk_we = 1'b1;
                wk_waddr = ch_r_reg;
                wk_wdata = pc_full ? pcode_reg
                         : {(pc_bits << 1) | MAX_CODE_LENGTH'(1), LW'(pc_len + 1'b1)};
            end
            S_FILL_RD, S_FILL_WAIT:
            begin
                nd_raddr = k_reg;
                wk_raddr = k_reg;
            end
            S_FILL_WR: ct_we = 1'b1;
            S_ENC_RD: ; // addresses from the held input symbol
            default: ;
        endcase
        if (state_reg == S_ENC_RD || state_reg == S_CNT_RD)
        begin
            cnt_raddr = sym_reg;
            ct_raddr = sym_reg;
        end
    end

    // Heap candidate comparison (scan): hp_rdata addresses the node RAM; both reads are registered
    logic cand_less;
    assign cand_less = (nd_w < best_w_reg) || ((nd_w == best_w_reg) && (nd_m < best_m_reg));

    logic [SW-1:0] scan_pos_reg;  // heap position whose node is in nd_rdata
    logic          scan_vld_reg;
    logic          hp_vld_reg;    // hp_rdata holds entry at scan_d_reg
    logic [SW-1:0] scan_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            idx_reg <= '0;
            built_reg <= 1'b0;
            distinct_reg <= '0;
            out_valid_reg <= 1'b0;
            hp_vld_reg <= 1'b0;
            scan_vld_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == (SW+1)'(ALPHABET_SIZE - 1))
                    begin
                        state_reg <= (out_valid_reg) ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        sym_reg <= in_sym[SW-1:0];
                        res_reg <= '{status: idle_status,
                                     distinct_count: (in_action == ACT_CLEAR)
                                         ? DistinctOutWidth'(0)
                                         : DistinctOutWidth'(distinct_reg),
                                     code_bits: '0, code_length: '0, frequency: '0};
                        if (in_action == ACT_CLEAR || idle_status != ST_OK)
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        case (in_action)
                            ACT_CLEAR:
                            begin
                                distinct_reg <= '0;
                                built_reg <= 1'b0;
                                idx_reg <= '0;
                                state_reg <= S_CLEAR;
                            end
                            ACT_COUNT:
                            begin
                                if (idle_status == ST_OK)
                                begin
                                    state_reg <= S_CNT_RD;
                                end
                            end
                            ACT_BUILD:
                            begin
                                if (idle_status == ST_OK)
                                begin
                                    idx_reg <= (SW+1)'(1);
                                    leaves_reg <= '0;
                                    hsize_reg <= '0;
                                    state_reg <= S_LEAF_RD;
                                end
                            end
                            default:
                            begin
                                if (idle_status == ST_OK)
                                begin
                                    state_reg <= S_ENC_RD;
                                end
                            end
                        endcase
                    end
                end
                S_CNT_RD: state_reg <= S_CNT_WR;
                S_CNT_WR:
                begin
                    if (cnt_rdata == CountMax)
                    begin
                        res_reg.status <= ST_SATURATED;
                        res_reg.frequency <= FreqOutWidth'(cnt_rdata);
                    end
                    else
                    begin
                        res_reg.frequency <= FreqOutWidth'(cnt_rdata + 1'b1);
                        if (cnt_rdata == '0)
                        begin
                            distinct_reg <= distinct_reg + 1'b1;
                            res_reg.distinct_count <= DistinctOutWidth'(distinct_reg + 1'b1);
                        end
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_ENC_RD: state_reg <= S_ENC_WAIT;
                S_ENC_WAIT:
                begin
                    if (cnt_rdata == '0)
                    begin
                        res_reg.status <= ST_ABSENT;
                    end
                    else
                    begin
                        res_reg.code_bits <= CodeOutWidth'(ct_rdata[CODEW-1:LW]);
                        res_reg.code_length <= LenOutWidth'(ct_rdata[LW-1:0]);
                        res_reg.frequency <= FreqOutWidth'(cnt_rdata);
                    end
                    out_valid_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                S_LEAF_RD: state_reg <= S_LEAF_CHK;
                S_LEAF_CHK:
                begin
                    if (cnt_rdata != '0)
                    begin
                        leaves_reg <= leaves_reg + 1'b1;
                        hsize_reg <= hsize_reg + 1'b1;
                    end
                    if (idx_reg == (SW+1)'(ALPHABET_SIZE - 1))
                    begin
                        next_reg <= (cnt_rdata != '0) ? NW'(leaves_reg + 1'b1) : leaves_reg;
                        state_reg <= S_SCAN_RD;
                        second_reg <= 1'b0;
                        scan_reg <= '0;
                        hp_vld_reg <= 1'b0;
                        scan_vld_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_LEAF_RD;
                    end
                end
                S_SCAN_RD:
                begin
                    // Start of a take: hsize_reg > 1 for first, >=1 for second
                    if (!second_reg && hsize_reg <= (HW)'(1))
                    begin
                        k_reg <= NW'(next_reg - 1'b1);
                        state_reg <= S_WALK_RD;
                    end
                    else
                    begin
                        best_w_reg <= '1;
                        best_m_reg <= '1;
                        scan_vld_reg <= 1'b0;
                        state_reg <= S_SCAN;
                        // entry 0 is read this cycle
                        scan_reg <= SW'(1);
                        scan_d_reg <= '0;
                        hp_vld_reg <= 1'b1;
                    end
                end
                S_SCAN:
                begin
                    // pipeline: hp_raddr=scan_reg; hp_rdata -> nd_raddr; nd_rdata compared
                    scan_vld_reg <= hp_vld_reg;
                    scan_pos_reg <= scan_d_reg;
                    if ((HW)'(scan_reg) < hsize_reg)
                    begin
                        scan_d_reg <= scan_reg;
                        scan_reg <= scan_reg + 1'b1;
                        hp_vld_reg <= 1'b1;
                    end
                    else
                    begin
                        hp_vld_reg <= 1'b0;
                    end
                    if (scan_vld_reg)
                    begin
                        if (cand_less || (best_w_reg == '1 && best_m_reg == '1
                                          && scan_pos_reg == '0))
                        begin
                            best_w_reg <= nd_w;
                            best_m_reg <= nd_m;
                            best_pos_reg <= scan_pos_reg;
                            best_node_reg <= nd_raddr_d_reg;
                        end
                    end
                    if (!hp_vld_reg && scan_vld_reg)
                    begin
                        state_reg <= S_TAKE_WR;
                    end
                end
                S_TAKE_WR:
                begin
                    // tail entry, read in the last scan cycle, fills the taken slot
                    state_reg <= S_MERGE_RD;
                end
                S_MERGE_RD:
                begin
                    hsize_reg <= hsize_reg - 1'b1;
                    if (!second_reg)
                    begin
                        a_node_reg <= best_node_reg;
                        a_w_reg <= best_w_reg;
                        a_m_reg <= best_m_reg;
                        second_reg <= 1'b1;
                        state_reg <= S_SCAN_RD;
                    end
                    else
                    begin
                        state_reg <= S_MERGE_WR;
                    end
                end
                S_MERGE_WR:
                begin
                    hsize_reg <= hsize_reg + 1'b1;
                    next_reg <= next_reg + 1'b1;
                    second_reg <= 1'b0;
                    state_reg <= S_SCAN_RD;
                end
                S_WALK_RD:
                begin
                    if (k_reg < leaves_reg)
                    begin
                        k_reg <= '0;
                        state_reg <= S_FILL_RD;
                    end
                    else
                    begin
                        state_reg <= S_WALK_WAIT;
                    end
                end
                S_WALK_WAIT:
                begin
                    ch_l_reg <= nd_left;
                    ch_r_reg <= nd_right;
                    // root entry written in S_WALK_RD is not yet in the read data
                    pcode_reg <= (k_reg == NW'(next_reg - 1'b1)) ? '0 : wk_rdata;
                    state_reg <= S_WALK_L;
                end
                S_WALK_L: state_reg <= S_WALK_R;
                S_WALK_R:
                begin
                    k_reg <= k_reg - 1'b1;
                    state_reg <= S_WALK_RD;
                end
                S_FILL_RD:
                begin
                    if (k_reg == leaves_reg)
                    begin
                        built_reg <= 1'b1;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_FILL_WAIT;
                    end
                end
                S_FILL_WAIT: state_reg <= S_FILL_WR;
                S_FILL_WR:
                begin
                    k_reg <= k_reg + 1'b1;
                    state_reg <= S_FILL_RD;
                end
                S_OUT: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        nd_raddr_d_reg <= nd_raddr;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = {7'd0, res_reg.frequency, res_reg.code_length,
                           res_reg.code_bits, res_reg.distinct_count, res_reg.status};

    // Assertions
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_axis_tready)
        else $error("accepted a word while the previous one is open");
    a_heap_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SCAN |-> hsize_reg <= HW'(ALPHABET_SIZE))
        else $error("heap overflow");
    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_TAKE_WR |-> last_pos < hsize_reg)
        else $error("bad heap tail");
endmodule

### dv/tb_huffman_code_builder_encoder_core.sv
// Testbench for huffman_code_builder_encoder_core: random and directed stream traffic, self-checked.
module tb_huffman_code_builder_encoder_core;
    import hcb_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit = 400000;   // a full-alphabet build runs long with no word moving
    localparam int HoldCycles = 300;
    localparam int CountMax   = 65535;

    // one pending input word, or a marker telling the sender to drain first
    typedef struct {
        logic        drain;
        action_t     act;
        logic [7:0]  sym;
    } pending_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // action[1:0], symbol[9:2]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;    // status, distinct_count, code_bits, code_length, frequency

    huffman_code_builder_encoder_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- encoder state mirror ----------------
    int                  sym_count [256];
    int                  n_distinct;
    logic                built;
    longint unsigned     code_of   [256];
    int                  len_of    [256];
    // tree scratch
    int                  nd_weight [512];
    int                  nd_minsym [512];
    int                  nd_left   [512];
    int                  nd_right  [512];
    int                  live      [256];
    int                  n_live;
    longint unsigned     path_code [512];
    int                  path_len  [512];

    pending_t  stim_q [$];
    result_t   result_q [$];
    int        errors;
    int        words_in;
    int        words_out;
    int        builds_done;
    int        hold_left;
    int        quiet_cycles;
    logic      hold_done;

    function automatic int pop_lightest();
        int best;
        int n;
        best = 0;
        for (int i = 1; i < n_live; i++)
        begin
            if (nd_weight[live[i]] < nd_weight[live[best]] ||
                (nd_weight[live[i]] == nd_weight[live[best]] &&
                 nd_minsym[live[i]] < nd_minsym[live[best]]))
                best = i;
        end
        n = live[best];
        n_live--;
        live[best] = live[n_live];
        return n;
    endfunction

    // Huffman merge, then walk from the root down assigning 0 left / 1 right
    function automatic void build_code_table();
        int leaves;
        int next;
        int a;
        int b;
        int ch;
        longint unsigned c;
        int l;
        leaves = 0;
        n_live = 0;
        for (int s = 1; s < 256; s++)
        begin
            if (sym_count[s] != 0)
            begin
                nd_weight[leaves] = sym_count[s];
                nd_minsym[leaves] = s;
                live[n_live++] = leaves;
                leaves++;
            end
        end
        next = leaves;
        while (n_live > 1)
        begin
            a = pop_lightest();
            b = pop_lightest();
            nd_left[next] = a;
            nd_right[next] = b;
            nd_weight[next] = nd_weight[a] + nd_weight[b];
            nd_minsym[next] = (nd_minsym[a] < nd_minsym[b]) ? nd_minsym[a] : nd_minsym[b];
            live[n_live++] = next;
            next++;
        end
        path_code[next-1] = 0;
        path_len[next-1] = 0;
        for (int k = next - 1; k >= leaves; k--)
        begin
            for (int bit_v = 0; bit_v < 2; bit_v++)
            begin
                ch = bit_v ? nd_right[k] : nd_left[k];
                c = path_code[k];
                l = path_len[k];
                if (l < 32)
                begin
                    c = (c << 1) | longint'(bit_v);
                    l++;
                end
                path_code[ch] = c;
                path_len[ch] = l;
            end
        end
        for (int k = 0; k < leaves; k++)
        begin
            code_of[nd_minsym[k]] = path_code[k];
            len_of[nd_minsym[k]] = path_len[k];
        end
    endfunction

    function automatic result_t predict_result(action_t act, logic [7:0] sym);
        result_t r;
        r = '0;
        r.status = ST_OK;
        case (act)
            ACT_CLEAR:
            begin
                foreach (sym_count[i]) sym_count[i] = 0;
                n_distinct = 0;
                built = 1'b0;
            end
            ACT_COUNT:
            begin
                if (sym == 0)
                    r.status = ST_ABSENT;
                else if (built)
                    r.status = ST_PHASE;
                else
                begin
                    if (sym_count[sym] >= CountMax)
                        r.status = ST_SATURATED;
                    else
                    begin
                        if (sym_count[sym] == 0)
                            n_distinct++;
                        sym_count[sym]++;
                    end
                    r.frequency = 16'(sym_count[sym]);
                end
            end
            ACT_BUILD:
            begin
                if (n_distinct == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    build_code_table();
                    built = 1'b1;
                    builds_done++;
                end
            end
            default:
            begin
                if (!built)
                    r.status = ST_PHASE;
                else if (sym == 0 || sym_count[sym] == 0)
                    r.status = ST_ABSENT;
                else
                begin
                    r.code_bits = code_of[sym][31:0];
                    r.code_length = len_of[sym][5:0];
                    r.frequency = 16'(sym_count[sym]);
                end
            end
        endcase
        r.distinct_count = n_distinct[7:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH word %0d: %s got 0x%0h expected 0x%0h", words_out, what, got, want);
        errors++;
    endtask

    task automatic push_word(action_t act, logic [7:0] sym);
        pending_t p;
        p.drain = 1'b0;
        p.act = act;
        p.sym = sym;
        stim_q.push_back(p);
    endtask

    task automatic push_drain();
        pending_t p;
        p.drain = 1'b1;
        p.act = ACT_CLEAR;
        p.sym = '0;
        stim_q.push_back(p);
    endtask

    // ---------------- sender ----------------
    // no idling while the receiver holds off, and none in a quiet window of words
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
            begin
                result_q.push_back(predict_result(action_t'(s_axis_tdata[1:0]),
                                                  s_axis_tdata[9:2]));
                words_in++;
            end
            if (stim_q.size() > 0 && stim_q[0].drain)
            begin
                // pause until every outstanding result has come back
                s_axis_tvalid <= 1'b0;
                if (result_q.size() == 0 && !s_axis_tvalid)
                    void'(stim_q.pop_front());
            end
            else if (stim_q.size() > 0 &&
                     (hold_left > 0 || (words_in > 400 && words_in < 700) ||
                      $urandom_range(99) >= 35))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {6'b0, stim_q[0].sym, stim_q[0].act};
                void'(stim_q.pop_front());
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // ---------------- receiver and checker ----------------
    always @(posedge clk or negedge rst_n)
    begin
        result_t got;
        result_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            hold_left     <= 0;
            hold_done     <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status         = status_t'(m_axis_tdata[2:0]);
                got.distinct_count = m_axis_tdata[10:3];
                got.code_bits      = m_axis_tdata[42:11];
                got.code_length    = m_axis_tdata[48:43];
                got.frequency      = m_axis_tdata[64:49];
                words_out++;
                if (result_q.size() == 0)
                begin
                    $display("UNEXPECTED result word %0d: 0x%0h", words_out, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = result_q.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.distinct_count != want.distinct_count)
                        report_mismatch("distinct_count", got.distinct_count,
                                        want.distinct_count);
                    if (got.code_bits != want.code_bits)
                        report_mismatch("code_bits", got.code_bits, want.code_bits);
                    if (got.code_length != want.code_length)
                        report_mismatch("code_length", got.code_length, want.code_length);
                    if (got.frequency != want.frequency)
                        report_mismatch("frequency", got.frequency, want.frequency);
                    if (m_axis_tdata[71:65] != '0)
                        report_mismatch("fill bits", m_axis_tdata[71:65], 0);
                end
            end
            // one long hold-off partway through, sender keeps pushing meanwhile
            if (!hold_done && words_out == 200)
            begin
                hold_left <= HoldCycles;
                hold_done <= 1'b1;
                m_axis_tready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_axis_tready <= (hold_left == 1);
            end
            else
                m_axis_tready <= (words_out > 400 && words_out < 700) ||
                                 ($urandom_range(99) >= 35);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("watchdog: no word moved for %0d cycles", StallLimit);
            $display("huffman_code_builder_encoder_core test failed");
            $finish;
        end
    end

    // ---------------- stimulus ----------------
    initial
    begin
        logic [7:0] alpha [$];
        int         n_alpha;
        int         n_count;
        int         r;
        logic [7:0] s;
        errors = 0;
        words_in = 0;
        words_out = 0;
        builds_done = 0;
        quiet_cycles = 0;
        n_distinct = 0;
        built = 1'b0;
        foreach (sym_count[i]) sym_count[i] = 0;
        rst_n = 1'b0;

        // directed: phase errors, empty build, zero symbol, lone symbol, rebuild
        push_word(ACT_ENCODE, 8'd1);
        push_word(ACT_BUILD, 8'd0);
        push_word(ACT_COUNT, 8'd0);
        push_word(ACT_COUNT, 8'd255);
        push_word(ACT_COUNT, 8'd1);
        push_word(ACT_COUNT, 8'd1);
        push_word(ACT_COUNT, 8'hAA);
        push_word(ACT_COUNT, 8'h55);
        push_word(ACT_BUILD, 8'hFF);
        push_word(ACT_ENCODE, 8'd1);
        push_word(ACT_ENCODE, 8'd255);
        push_word(ACT_ENCODE, 8'hAA);
        push_word(ACT_ENCODE, 8'd0);
        push_word(ACT_ENCODE, 8'd5);
        push_word(ACT_COUNT, 8'd1);
        push_word(ACT_BUILD, 8'd0);
        push_word(ACT_ENCODE, 8'h55);
        push_word(ACT_CLEAR, 8'hFF);
        push_word(ACT_COUNT, 8'd9);
        push_word(ACT_BUILD, 8'd0);
        push_word(ACT_ENCODE, 8'd9);
        push_word(ACT_CLEAR, 8'd0);
        push_drain();

        // random sessions: clear, count over a chosen alphabet, build, encode
        for (int sess = 0; stim_q.size() < 1420; sess++)
        begin
            alpha.delete();
            if (sess == 2 || sess == 9)
                n_alpha = 255;
            else
                n_alpha = $urandom_range(12, 1);
            if (n_alpha == 255)
                for (int i = 1; i < 256; i++) alpha.push_back(i[7:0]);
            else
                for (int i = 0; i < n_alpha; i++) alpha.push_back(8'($urandom_range(255, 1)));
            push_word(ACT_CLEAR, 8'($urandom_range(255)));
            if (n_alpha == 255)
                foreach (alpha[i]) push_word(ACT_COUNT, alpha[i]);
            n_count = $urandom_range(30, 1);
            for (int i = 0; i < n_count; i++)
            begin
                r = $urandom_range(99);
                if (r < 88)
                    push_word(ACT_COUNT, alpha[$urandom_range(alpha.size() - 1)]);
                else if (r < 94)
                    push_word(ACT_COUNT, 8'd0);
                else
                    push_word(action_t'($urandom_range(3, 1)), 8'($urandom_range(255)));
            end
            push_word(ACT_BUILD, 8'($urandom_range(255)));
            n_count = $urandom_range(12, 1);
            for (int i = 0; i < n_count; i++)
            begin
                r = $urandom_range(99);
                s = (r < 80) ? alpha[$urandom_range(alpha.size() - 1)]
                             : 8'($urandom_range(255));
                if (r >= 95)
                    push_word(ACT_COUNT, s);
                else if (r >= 92)
                    push_word(ACT_BUILD, s);
                else
                    push_word(ACT_ENCODE, s);
            end
            if (sess == 12)
                push_drain();
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        wait (stim_q.size() == 0 && !s_axis_tvalid && result_q.size() == 0);
        repeat (100) @(posedge clk);
        $display("covered %0d words in, %0d results checked, %0d code builds",
                 words_in, words_out, builds_done);
        $display("including lone symbol, full alphabet, zero symbol and phase errors");
        if (errors == 0 && result_q.size() == 0)
            $display("huffman_code_builder_encoder_core test passed");
        else
            $display("huffman_code_builder_encoder_core test failed");
        $finish;
    end

endmodule

### sim.f
rtl/core/hcb_pkg.sv
rtl/core/hcb_ram.sv
rtl/core/huffman_code_builder_encoder_core.sv
dv/tb_huffman_code_builder_encoder_core.sv
